// ===== rtl/core/lgs_pkg.sv =====
// Shared types and constants for the life generation stream core.
package lgs_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int GW_W    = COL_W + 1;
	localparam int GH_W    = ROW_W + 1;
	localparam int CFG_W   = (GW_W > GH_W) ? GW_W : GH_W;
	localparam int NCOUNT_W = 4;

	localparam logic [GW_W-1:0] GW_MIN   = GW_W'(3);
	localparam logic [GW_W-1:0] GW_RESET = GW_W'(MAX_WIDTH);
	localparam logic [GH_W-1:0] GH_MIN   = GH_W'(3);
	localparam logic [GH_W-1:0] GH_RESET = GH_W'(MAX_HEIGHT);

	localparam logic [NCOUNT_W-1:0] BIRTH_COUNT   = NCOUNT_W'(3);
	localparam logic [NCOUNT_W-1:0] SURVIVE_COUNT = NCOUNT_W'(2);

	typedef enum logic [0:0] {
		CFG_GRID_WIDTH  = 1'b0,
		CFG_GRID_HEIGHT = 1'b1
	} cfg_index_t;

	// 3x3 neighborhood, column c-2 in the top bits, each column (r-2, r-1, r).
	typedef struct packed {
		logic [8:0] block;
		logic       inner;
	} rule_req_t;

endpackage

// ===== rtl/core/lgs_cell_rule.sv =====
// Next-state rule B3/S23 for one 3x3 neighborhood.
module lgs_cell_rule (
	input  lgs_pkg::rule_req_t req,
	output logic               next_alive
);

	logic                         center;
	logic [lgs_pkg::NCOUNT_W-1:0] neighbors;

	always_comb begin
		center    = req.block[4];
		neighbors = lgs_pkg::NCOUNT_W'($countones({req.block[8:5], req.block[3:0]}));
		next_alive = 1'b0;
		if (req.inner) begin
			if (neighbors == lgs_pkg::BIRTH_COUNT) begin
				next_alive = 1'b1;
			end else if (neighbors == lgs_pkg::SURVIVE_COUNT) begin
				next_alive = center;
			end
		end
	end

endmodule

// ===== rtl/core/life_generation_stream_core.sv =====
// Pipeline: the line store is read into stage 1 at acceptance; when stage 1 moves on, the rule
// result for the cell one row up and one column left is evaluated into the output register.
// Throughput: one cell per clock cycle; the single-port-per-side line store and the
// output register set that rate, and a stalled output holds the pipe.
// Reset clears the counters, the window, the valid flags and sets the grid to its maximum.
// The line store is not cleared; every entry in use is written in the first row of a frame.
module life_generation_stream_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [lgs_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cell_alive,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lgs_pkg::ROW_W-1:0]   out_row,
	output logic [lgs_pkg::COL_W-1:0]   out_col,
	output logic                        next_alive,
	output logic                        frame_last
);

	localparam int COL_W = lgs_pkg::COL_W;
	localparam int ROW_W = lgs_pkg::ROW_W;
	localparam int GW_W  = lgs_pkg::GW_W;
	localparam int GH_W  = lgs_pkg::GH_W;

	logic [GW_W-1:0]  grid_width_q;
	logic [GH_W-1:0]  grid_height_q;
	logic [GW_W-1:0]  cfg_w_val;
	logic [GH_W-1:0]  cfg_h_val;

	logic [ROW_W-1:0] row_count_q;
	logic [COL_W-1:0] col_count_q;

	logic [1:0]       row_store [lgs_pkg::MAX_WIDTH];
	logic [1:0]       store_rd_s1;

	logic             valid_s1;
	logic             cell_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;
	logic [5:0]       window_q;

	logic             out_valid_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic             next_alive_q;
	logic             frame_last_q;

	logic             accept_in;
	logic             advance_s1;
	logic             produce_s1;
	logic [2:0]       column3;
	logic             inner_s1;
	logic             last_s1;
	logic             rule_next;
	lgs_pkg::rule_req_t rule_req;

	// Configuration: clamp into the legal range.
	always_comb begin
		cfg_w_val = cfg_data[GW_W-1:0];
		if (cfg_w_val < lgs_pkg::GW_MIN) begin
			cfg_w_val = lgs_pkg::GW_MIN;
		end else if (cfg_w_val > lgs_pkg::GW_RESET) begin
			cfg_w_val = lgs_pkg::GW_RESET;
		end
		cfg_h_val = cfg_data[GH_W-1:0];
		if (cfg_h_val < lgs_pkg::GH_MIN) begin
			cfg_h_val = lgs_pkg::GH_MIN;
		end else if (cfg_h_val > lgs_pkg::GH_RESET) begin
			cfg_h_val = lgs_pkg::GH_RESET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= lgs_pkg::GW_RESET;
			grid_height_q <= lgs_pkg::GH_RESET;
		end else if (cfg_we) begin
			unique case (lgs_pkg::cfg_index_t'(cfg_index))
				lgs_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_w_val;
				lgs_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_h_val;
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 moves on when the output register is empty or being drained.
	assign advance_s1 = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;
	assign accept_in  = in_valid && !in_stall;

	// Raster position of the next input transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
			col_count_q <= '0;
		end else if (accept_in) begin
			if ({1'b0, col_count_q} + GW_W'(1) >= grid_width_q) begin
				col_count_q <= '0;
				if ({1'b0, row_count_q} + GH_W'(1) >= grid_height_q) begin
					row_count_q <= '0;
				end else begin
					row_count_q <= row_count_q + ROW_W'(1);
				end
			end else begin
				col_count_q <= col_count_q + COL_W'(1);
			end
		end
	end

	// Line store: read on acceptance, written back when stage 1 moves on. The same
	// column is read again only a full row later, so the late write never races a read.
	always_ff @(posedge clk) begin
		if (accept_in) begin
			store_rd_s1 <= row_store[col_count_q];
		end
		if (advance_s1) begin
			row_store[col_s1] <= column3[1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			cell_s1 <= cell_alive;
			row_s1  <= row_count_q;
			col_s1  <= col_count_q;
		end
	end

	assign column3 = {store_rd_s1, cell_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (advance_s1) begin
			window_q <= {window_q[2:0], column3};
		end
	end

	// The result cell is (row_s1-1, col_s1-1); it is inner when both indexes are at least
	// one and stay two short of the grid size.
	always_comb begin
		produce_s1 = (row_s1 != '0) && (col_s1 != '0);
		inner_s1   = (row_s1 >= ROW_W'(2)) && (col_s1 >= COL_W'(2)) &&
			({1'b0, row_s1} < grid_height_q) && ({1'b0, col_s1} < grid_width_q);
		last_s1    = ({1'b0, row_s1} + GH_W'(1) == grid_height_q) &&
			({1'b0, col_s1} + GW_W'(1) == grid_width_q);
		rule_req.block = {window_q, column3};
		rule_req.inner = inner_s1;
	end

	lgs_cell_rule u_rule (
		.req        (rule_req),
		.next_alive (rule_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && produce_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && produce_s1) begin
			out_row_q    <= row_s1 - ROW_W'(1);
			out_col_q    <= col_s1 - COL_W'(1);
			next_alive_q <= rule_next;
			frame_last_q <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign next_alive = next_alive_q;
	assign frame_last = frame_last_q;

	// Cells on the top or left border never come out alive.
	a_border_dead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && next_alive |-> out_row != '0 && out_col != '0)
		else $error("live result on the top or left border");

	// A held stage 1 keeps its position for the next cycle.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance_s1 |=> valid_s1 && $stable(col_s1) && $stable(row_s1))
		else $error("stage 1 lost its transaction while held");

	// The frame end marker sits two columns short of the grid width.
	a_frame_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> {1'b0, out_col} + GW_W'(2) == grid_width_q)
		else $error("frame end marker on the wrong column");

	// A full output register that is stalled blocks the input side when stage 1 is full.
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && valid_s1 |-> in_stall)
		else $error("input accepted into a blocked pipeline");

endmodule
